FILE: design/arp_snooping_device_table_macros.svh
// Assertion macros shared by the ARP snooping device table RTL.
// Depends on a clock named clk and an active-low reset named rst_n in the using module.
`ifndef ARP_SNOOPING_DEVICE_TABLE_MACROS_SVH
`define ARP_SNOOPING_DEVICE_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARPSDT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ARPSDT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/arpsdt_pkg.sv
// Shared types, codes and sizes for the ARP snooping device table.
// No dependencies; used by arpsdt_table and arp_snooping_device_table.
package arpsdt_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 32;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [CNT_W-1:0] cnt_t;
    typedef logic [31:0]      ip_t;
    typedef logic [47:0]      mac_t;
    typedef logic [1:0]       status_t;
    typedef logic [2:0]       outcome_t;

    // Commands.
    localparam logic [1:0] CMD_LEARN   = 2'd0;
    localparam logic [1:0] CMD_BLOCK   = 2'd1;
    localparam logic [1:0] CMD_UNBLOCK = 2'd2;

    // Entry status codes.
    localparam status_t ST_TRUSTED   = 2'd0;
    localparam status_t ST_UNTRUSTED = 2'd1;
    localparam status_t ST_BLOCKED   = 2'd2;

    // Result outcome codes.
    localparam outcome_t OC_ADDED      = 3'd0;
    localparam outcome_t OC_KNOWN      = 3'd1;
    localparam outcome_t OC_ZERO_IP    = 3'd2;
    localparam outcome_t OC_FULL       = 3'd3;
    localparam outcome_t OC_IGNORED    = 3'd4;
    localparam outcome_t OC_BAD_HEADER = 3'd5;
    localparam outcome_t OC_MARKED     = 3'd6;
    localparam outcome_t OC_NOT_FOUND  = 3'd7;

    // Frame header values.
    localparam logic [10:0] MIN_FRAME_LEN  = 11'd14;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [15:0] HTYPE_ETHERNET = 16'h0001;
    localparam logic [15:0] PTYPE_IPV4     = 16'h0800;
    localparam logic [7:0]  HLEN_ETHERNET  = 8'd6;
    localparam logic [7:0]  PLEN_IPV4      = 8'd4;

    // Write request into the table memories.
    typedef struct packed {
        logic    en_entry;
        logic    en_status;
        idx_t    addr;
        ip_t     ip;
        mac_t    mac;
        status_t status;
    } tbl_wr_t;

endpackage

FILE: design/arpsdt_table.sv
// Device table storage: IP, MAC and status memories with one registered read port.
// Depends on arpsdt_pkg for sizes and the write request struct.
module arpsdt_table
    import arpsdt_pkg::*;
(
    input  logic    clk,
    input  logic    rd_en,
    input  idx_t    rd_addr,
    output ip_t     rd_ip,
    output status_t rd_status,
    input  tbl_wr_t wr
);

    ip_t     ip_mem     [TABLE_ENTRIES];
    mac_t    mac_mem    [TABLE_ENTRIES];
    status_t status_mem [TABLE_ENTRIES];

    ip_t     rd_ip_reg;
    status_t rd_status_reg;

    // Write port: an append writes the whole entry, a mark only the status.
    always_ff @(posedge clk)
    begin
        if (wr.en_entry)
        begin
            ip_mem[wr.addr]  <= wr.ip;
            mac_mem[wr.addr] <= wr.mac;
        end
        if (wr.en_entry || wr.en_status)
        begin
            status_mem[wr.addr] <= wr.status;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_ip_reg     <= ip_mem[rd_addr];
            rd_status_reg <= status_mem[rd_addr];
        end
    end

    assign rd_ip     = rd_ip_reg;
    assign rd_status = rd_status_reg;

endmodule

FILE: design/arp_snooping_device_table.sv
// Top level of the ARP snooping device table: command decode, table search and results.
// Depends on arpsdt_pkg, arpsdt_table and arp_snooping_device_table_macros.svh.
//
//   Channel  Direction  Handshake              Payload
//   in       sink       in_valid / in_stall    command, frame fields, ip_address, sender_mac
//   out      source     out_valid / out_stall  outcome, entry_index, entry_status, fill_count
//   cfg      sink       cfg_valid / cfg_ready  cfg_data (arp_enabled)
//
// One item is handled at a time. An item rejected by the header checks skips the scan.
// Any other item scans the used entries through the single table read port, one entry a
// cycle, until an entry matches or every used entry has been read.
// Reset empties the table by clearing the fill count; entries are never read above it.
// A waiting result does not block the next item; only the final result load waits on out_stall.
`include "arp_snooping_device_table_macros.svh"

module arp_snooping_device_table
    import arpsdt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  command,
    input  logic [10:0] frame_length,
    input  logic [15:0] ether_type,
    input  logic [15:0] hardware_type,
    input  logic [15:0] protocol_type,
    input  logic [7:0]  hardware_length,
    input  logic [7:0]  protocol_length,
    input  logic [31:0] ip_address,
    input  logic [47:0] sender_mac,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  outcome,
    output logic [4:0]  entry_index,
    output logic [1:0]  entry_status,
    output logic [5:0]  fill_count,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // Control state.
    logic [1:0] state_reg, state_next;
    cnt_t       issue_reg, issue_next;
    logic       cmp_valid_reg, cmp_valid_next;
    cnt_t       used_reg, used_next;
    logic       arp_en_reg, arp_en_next;
    logic       out_valid_reg, out_valid_next;

    // Payload state.
    logic [1:0] cmd_reg, cmd_next;
    ip_t        ip_reg, ip_next;
    mac_t       mac_reg, mac_next;
    idx_t       cmp_idx_reg, cmp_idx_next;
    outcome_t   res_outcome_reg, res_outcome_next;
    idx_t       res_idx_reg, res_idx_next;
    status_t    res_status_reg, res_status_next;
    outcome_t   out_outcome_reg, out_outcome_next;
    logic [4:0] out_index_reg, out_index_next;
    status_t    out_status_reg, out_status_next;
    logic [5:0] out_fill_reg, out_fill_next;

    // Table port.
    logic    rd_en;
    idx_t    rd_addr;
    ip_t     rd_ip;
    status_t rd_status;
    tbl_wr_t wr;

    // Decode of the incoming item.
    logic is_mark;
    logic is_learn;
    logic frame_ignored;
    logic header_bad;
    logic scan_hit;
    logic scan_done;

    arpsdt_table u_table (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_ip     (rd_ip),
        .rd_status (rd_status),
        .wr        (wr)
    );

    // Header checks on the item at the input port.
    always_comb
    begin
        is_mark  = (command == CMD_BLOCK) || (command == CMD_UNBLOCK);
        is_learn = (command == CMD_LEARN);
        frame_ignored = !is_mark && (!is_learn || (frame_length <= MIN_FRAME_LEN)
                        || (ether_type != ETHERTYPE_ARP) || !arp_en_reg);
        header_bad = (hardware_type != HTYPE_ETHERNET) || (hardware_length != HLEN_ETHERNET)
                     || (protocol_length != PLEN_IPV4) || (protocol_type != PTYPE_IPV4);
    end

    // Search status: the entry read last cycle matches, or every used entry has been read.
    assign scan_hit  = cmp_valid_reg && (rd_ip == ip_reg);
    assign scan_done = (issue_reg >= used_reg);

    // Sequencer: accept, scan the table, write back, hand over the result.
    always_comb
    begin
        state_next       = state_reg;
        issue_next       = issue_reg;
        cmp_valid_next   = cmp_valid_reg;
        used_next        = used_reg;
        arp_en_next      = arp_en_reg;
        out_valid_next   = out_valid_reg;
        cmd_next         = cmd_reg;
        ip_next          = ip_reg;
        mac_next         = mac_reg;
        cmp_idx_next     = cmp_idx_reg;
        res_outcome_next = res_outcome_reg;
        res_idx_next     = res_idx_reg;
        res_status_next  = res_status_reg;
        out_outcome_next = out_outcome_reg;
        out_index_next   = out_index_reg;
        out_status_next  = out_status_reg;
        out_fill_next    = out_fill_reg;
        rd_en            = 1'b0;
        rd_addr          = issue_reg[IDX_W-1:0];
        wr               = '0;

        if (cfg_valid && cfg_ready)
        begin
            arp_en_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = command;
                    ip_next         = ip_address;
                    mac_next        = sender_mac;
                    issue_next      = '0;
                    cmp_valid_next  = 1'b0;
                    res_idx_next    = '0;
                    res_status_next = ST_TRUSTED;
                    if (frame_ignored)
                    begin
                        res_outcome_next = OC_IGNORED;
                        state_next       = S_FINISH;
                    end
                    else if (is_learn && header_bad)
                    begin
                        res_outcome_next = OC_BAD_HEADER;
                        state_next       = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (scan_hit)
                begin
                    res_idx_next = cmp_idx_reg;
                    if (cmd_reg == CMD_LEARN)
                    begin
                        res_outcome_next = OC_KNOWN;
                        res_status_next  = rd_status;
                    end
                    else
                    begin
                        wr.en_status     = 1'b1;
                        wr.addr          = cmp_idx_reg;
                        wr.status        = (cmd_reg == CMD_BLOCK) ? ST_BLOCKED : ST_UNTRUSTED;
                        res_outcome_next = OC_MARKED;
                        res_status_next  = wr.status;
                    end
                    state_next = S_FINISH;
                end
                else if (scan_done)
                begin
                    res_idx_next    = '0;
                    res_status_next = ST_TRUSTED;
                    if (cmd_reg != CMD_LEARN)
                    begin
                        res_outcome_next = OC_NOT_FOUND;
                    end
                    else if (ip_reg == '0)
                    begin
                        res_outcome_next = OC_ZERO_IP;
                    end
                    else if (used_reg >= CNT_W'(TABLE_ENTRIES))
                    begin
                        res_outcome_next = OC_FULL;
                    end
                    else
                    begin
                        // Append the new device as untrusted.
                        wr.en_entry      = 1'b1;
                        wr.addr          = used_reg[IDX_W-1:0];
                        wr.ip            = ip_reg;
                        wr.mac           = mac_reg;
                        wr.status        = ST_UNTRUSTED;
                        used_next        = used_reg + 1'b1;
                        res_outcome_next = OC_ADDED;
                        res_idx_next     = used_reg[IDX_W-1:0];
                        res_status_next  = ST_UNTRUSTED;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    rd_en          = 1'b1;
                    cmp_idx_next   = issue_reg[IDX_W-1:0];
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    out_outcome_next = res_outcome_reg;
                    out_index_next   = 5'(res_idx_reg);
                    out_status_next  = res_status_reg;
                    out_fill_next    = 6'(used_reg);
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            used_reg      <= '0;
            arp_en_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
            used_reg      <= used_next;
            arp_en_reg    <= arp_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        ip_reg          <= ip_next;
        mac_reg         <= mac_next;
        cmp_idx_reg     <= cmp_idx_next;
        res_outcome_reg <= res_outcome_next;
        res_idx_reg     <= res_idx_next;
        res_status_reg  <= res_status_next;
        out_outcome_reg <= out_outcome_next;
        out_index_reg   <= out_index_next;
        out_status_reg  <= out_status_next;
        out_fill_reg    <= out_fill_next;
    end

    // Port drive.
    assign in_stall     = (state_reg != S_IDLE);
    assign cfg_ready    = 1'b1;
    assign out_valid    = out_valid_reg;
    assign outcome      = out_outcome_reg;
    assign entry_index  = out_index_reg;
    assign entry_status = out_status_reg;
    assign fill_count   = out_fill_reg;

    // The fill count stays within the table and only ever grows by one.
    `ARPSDT_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= CNT_W'(TABLE_ENTRIES),
        "fill count exceeds table size")
    `ARPSDT_ASSERT_NEXT(a_used_step, 1'b1,
        (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + 1'b1),
        "fill count moved by more than one")

    // Table writes only close a scan, and an append lands at the fill count.
    `ARPSDT_ASSERT_NOW(a_write_in_scan, wr.en_entry || wr.en_status, state_reg == S_SCAN,
        "table written outside a scan")
    `ARPSDT_ASSERT_NOW(a_append_addr, wr.en_entry, wr.addr == used_reg[IDX_W-1:0],
        "append address differs from fill count")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for arp_snooping_device_table: directed and random learn/mark items.
// Depends on arpsdt_pkg and the arp_snooping_device_table RTL; predicts each result itself.
module testbench;
    import arpsdt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // One input item as presented on the in channel.
    typedef struct {
        logic [1:0]  command;
        logic [10:0] frame_length;
        logic [15:0] ether_type;
        logic [15:0] hardware_type;
        logic [15:0] protocol_type;
        logic [7:0]  hardware_length;
        logic [7:0]  protocol_length;
        ip_t         ip_address;
        mac_t        sender_mac;
    } arp_item_t;

    // One result item as seen on the out channel.
    typedef struct {
        outcome_t    outcome;
        logic [4:0]  entry_index;
        status_t     entry_status;
        logic [5:0]  fill_count;
    } table_result_t;

    // Scoreboard: keeps its own copy of the device table and the queue of awaited results.
    class device_table_scoreboard;
        ip_t           known_ip[TABLE_ENTRIES];
        status_t       known_status[TABLE_ENTRIES];
        int unsigned   used;
        logic          arp_on;
        table_result_t awaited[$];
        int            errors;
        int            items_noted;
        int            results_seen;
        logic [7:0]    kinds_seen;
        int unsigned   peak_fill;

        function new();
            used = 0;
            arp_on = 1'b1;
            errors = 0;
            items_noted = 0;
            results_seen = 0;
            kinds_seen = '0;
            peak_fill = 0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void set_arp_enable(logic value);
            arp_on = value;
        endfunction

        // First used entry holding ip, or -1.
        function int find_entry(ip_t ip);
            for (int i = 0; i < int'(used); i++)
            begin
                if (known_ip[i] == ip)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        // Apply one accepted item to the table copy and queue the result it must produce.
        function void note_item(arp_item_t it);
            table_result_t want;
            int            hit;
            want.outcome = OC_IGNORED;
            want.entry_index = '0;
            want.entry_status = ST_TRUSTED;
            hit = find_entry(it.ip_address);
            if (it.command == CMD_BLOCK || it.command == CMD_UNBLOCK)
            begin
                if (hit < 0)
                begin
                    want.outcome = OC_NOT_FOUND;
                end
                else
                begin
                    known_status[hit] = (it.command == CMD_BLOCK) ? ST_BLOCKED : ST_UNTRUSTED;
                    want.outcome = OC_MARKED;
                    want.entry_index = 5'(hit);
                    want.entry_status = known_status[hit];
                end
            end
            else if (it.command != CMD_LEARN || it.frame_length <= MIN_FRAME_LEN
                     || it.ether_type != ETHERTYPE_ARP || !arp_on)
            begin
                want.outcome = OC_IGNORED;
            end
            else if (it.hardware_type != HTYPE_ETHERNET || it.hardware_length != HLEN_ETHERNET
                     || it.protocol_length != PLEN_IPV4 || it.protocol_type != PTYPE_IPV4)
            begin
                want.outcome = OC_BAD_HEADER;
            end
            else if (hit >= 0)
            begin
                want.outcome = OC_KNOWN;
                want.entry_index = 5'(hit);
                want.entry_status = known_status[hit];
            end
            else if (it.ip_address == '0)
            begin
                want.outcome = OC_ZERO_IP;
            end
            else if (used >= TABLE_ENTRIES)
            begin
                want.outcome = OC_FULL;
            end
            else
            begin
                known_ip[used] = it.ip_address;
                known_status[used] = ST_UNTRUSTED;
                want.outcome = OC_ADDED;
                want.entry_index = 5'(used);
                want.entry_status = ST_UNTRUSTED;
                used++;
            end
            want.fill_count = 6'(used);
            if (used > peak_fill)
            begin
                peak_fill = used;
            end
            awaited.push_back(want);
            items_noted++;
        endfunction

        task report_mismatch(string what, int got, int want);
            errors++;
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        // Compare one accepted result with the oldest awaited one.
        task check_result(table_result_t got);
            table_result_t want;
            results_seen++;
            kinds_seen[got.outcome] = 1'b1;
            if (awaited.size() == 0)
            begin
                report_mismatch("result with nothing awaited, outcome", int'(got.outcome), -1);
            end
            else
            begin
                want = awaited.pop_front();
                if (got.outcome !== want.outcome)
                begin
                    report_mismatch("outcome", int'(got.outcome), int'(want.outcome));
                end
                if (got.entry_index !== want.entry_index)
                begin
                    report_mismatch("entry_index", int'(got.entry_index), int'(want.entry_index));
                end
                if (got.entry_status !== want.entry_status)
                begin
                    report_mismatch("entry_status", int'(got.entry_status),
                                    int'(want.entry_status));
                end
                if (got.fill_count !== want.fill_count)
                begin
                    report_mismatch("fill_count", int'(got.fill_count), int'(want.fill_count));
                end
            end
        endtask
    endclass

    // Block ports.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  command = '0;
    logic [10:0] frame_length = '0;
    logic [15:0] ether_type = '0;
    logic [15:0] hardware_type = '0;
    logic [15:0] protocol_type = '0;
    logic [7:0]  hardware_length = '0;
    logic [7:0]  protocol_length = '0;
    logic [31:0] ip_address = '0;
    logic [47:0] sender_mac = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  outcome;
    logic [4:0]  entry_index;
    logic [1:0]  entry_status;
    logic [5:0]  fill_count;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b0;

    device_table_scoreboard sb;
    ip_t addr_pool[40];
    int  burst_left = 0;
    int  stall_mode = 0;
    int  stall_left = 0;

    arp_snooping_device_table u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .frame_length    (frame_length),
        .ether_type      (ether_type),
        .hardware_type   (hardware_type),
        .protocol_type   (protocol_type),
        .hardware_length (hardware_length),
        .protocol_length (protocol_length),
        .ip_address      (ip_address),
        .sender_mac      (sender_mac),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .outcome         (outcome),
        .entry_index     (entry_index),
        .entry_status    (entry_status),
        .fill_count      (fill_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // 4 ns clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver stall pattern: free, light or heavy stalling, each for a random stretch.
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_stall = 1'b0;
            1: out_stall = ($urandom_range(0, 99) < 30);
            default: out_stall = ($urandom_range(0, 99) < 75);
        endcase
    end

    // Result checking at the rising edge.
    always @(posedge clk)
    begin
        table_result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.outcome = outcome;
            got.entry_index = entry_index;
            got.entry_status = entry_status;
            got.fill_count = fill_count;
            sb.check_result(got);
        end
    end

    function automatic mac_t random_mac();
        return {16'($urandom), $urandom};
    endfunction

    // Well-formed learn item for the given sender.
    function automatic arp_item_t good_learn(ip_t ip, mac_t mac);
        arp_item_t it;
        it.command = CMD_LEARN;
        it.frame_length = 11'($urandom_range(15, 2047));
        it.ether_type = ETHERTYPE_ARP;
        it.hardware_type = HTYPE_ETHERNET;
        it.protocol_type = PTYPE_IPV4;
        it.hardware_length = HLEN_ETHERNET;
        it.protocol_length = PLEN_IPV4;
        it.ip_address = ip;
        it.sender_mac = mac;
        return it;
    endfunction

    function automatic arp_item_t mark_item(logic [1:0] cmd, ip_t ip);
        arp_item_t it;
        it = good_learn(ip, random_mac());
        it.command = cmd;
        // Frame fields are don't-care for marking; randomize them.
        it.frame_length = 11'($urandom);
        it.ether_type = 16'($urandom);
        it.hardware_type = 16'($urandom);
        it.protocol_type = 16'($urandom);
        it.hardware_length = 8'($urandom);
        it.protocol_length = 8'($urandom);
        return it;
    endfunction

    // Mostly addresses from a pool a bit larger than the table, some fresh ones, rarely zero.
    function automatic ip_t pick_ip();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return '0;
        end
        else if (r < 13)
        begin
            return $urandom;
        end
        return addr_pool[$urandom_range(0, 39)];
    endfunction

    // Learn item with one field broken, or an unknown command.
    function automatic arp_item_t broken_learn();
        arp_item_t it;
        it = good_learn(pick_ip(), random_mac());
        case ($urandom_range(0, 6))
            0: it.frame_length = 11'($urandom_range(0, 14));
            1: it.ether_type = 16'($urandom);
            2: it.hardware_type = 16'($urandom);
            3: it.protocol_type = 16'($urandom);
            4: it.hardware_length = 8'($urandom);
            5: it.protocol_length = 8'($urandom);
            default: it.command = 2'd3;
        endcase
        return it;
    endfunction

    // Random fields, each header field often at its legal value.
    function automatic arp_item_t noise_item();
        arp_item_t it;
        it.command = 2'($urandom);
        it.frame_length = 11'($urandom);
        it.ether_type = $urandom_range(0, 1) ? ETHERTYPE_ARP : 16'($urandom);
        it.hardware_type = $urandom_range(0, 1) ? HTYPE_ETHERNET : 16'($urandom);
        it.protocol_type = $urandom_range(0, 1) ? PTYPE_IPV4 : 16'($urandom);
        it.hardware_length = $urandom_range(0, 1) ? HLEN_ETHERNET : 8'($urandom);
        it.protocol_length = $urandom_range(0, 1) ? PLEN_IPV4 : 8'($urandom);
        it.ip_address = $urandom_range(0, 1) ? pick_ip() : ip_t'($urandom);
        it.sender_mac = random_mac();
        return it;
    endfunction

    // Send one item in bursts with random gaps.
    task automatic send_paced(input arp_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        command = it.command;
        frame_length = it.frame_length;
        ether_type = it.ether_type;
        hardware_type = it.hardware_type;
        protocol_type = it.protocol_type;
        hardware_length = it.hardware_length;
        protocol_length = it.protocol_length;
        ip_address = it.ip_address;
        sender_mac = it.sender_mac;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        sb.note_item(it);
    endtask

    // Hold off the sender until every awaited result is in, then let the block settle.
    task automatic wait_for_results();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_arp_enable(input logic value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        sb.set_arp_enable(value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Run limit.
    initial
    begin
        #3_000_000;
        $display("[arp_snooping_device_table] ERROR");
        $finish;
    end

    // Main stimulus.
    initial
    begin
        arp_item_t it;
        int        phase_on[5];
        int        phase_items[5];
        int        done_items;
        sb = new();
        phase_on = '{1, 0, 1, 0, 1};
        phase_items = '{220, 60, 220, 60, 140};
        for (int i = 0; i < 40; i++)
        begin
            addr_pool[i] = $urandom | 32'h1;
        end
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty-table mark, three ignore and four bad-header reasons, zero address.
        send_paced(mark_item(CMD_BLOCK, 32'h0A00_0001));
        it = good_learn(32'h0A00_0001, random_mac());
        it.frame_length = MIN_FRAME_LEN;
        send_paced(it);
        it = good_learn(32'h0A00_0001, random_mac());
        it.frame_length = 11'h7FF;
        it.ether_type = PTYPE_IPV4;
        send_paced(it);
        it = good_learn(32'h0A00_0001, random_mac());
        it.command = 2'd3;
        send_paced(it);
        send_paced(good_learn('0, random_mac()));
        it = good_learn(32'h0A00_0001, random_mac());
        it.hardware_type = 16'hFFFF;
        send_paced(it);
        it = good_learn(32'h0A00_0001, random_mac());
        it.protocol_type = 16'h0000;
        send_paced(it);
        it = good_learn(32'h0A00_0001, random_mac());
        it.hardware_length = 8'hFF;
        send_paced(it);
        it = good_learn(32'h0A00_0001, random_mac());
        it.protocol_length = 8'h00;
        send_paced(it);

        // Directed: extreme addresses, known address, block and unblock.
        it = good_learn(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        it.frame_length = 11'd15;
        send_paced(it);
        send_paced(good_learn(32'hFFFF_FFFF, '0));
        send_paced(good_learn(32'h0000_0001, '0));
        send_paced(mark_item(CMD_BLOCK, 32'hFFFF_FFFF));
        send_paced(good_learn(32'hFFFF_FFFF, random_mac()));
        send_paced(mark_item(CMD_UNBLOCK, 32'hFFFF_FFFF));
        send_paced(mark_item(CMD_UNBLOCK, 32'h0000_0001));
        send_paced(mark_item(CMD_BLOCK, 32'h0A00_0002));

        // Directed: with ARP disabled a learn is ignored but marking still works.
        wait_for_results();
        write_arp_enable(1'b0);
        send_paced(good_learn(32'h0A00_0003, random_mac()));
        send_paced(mark_item(CMD_BLOCK, 32'h0000_0001));
        wait_for_results();

        // Random phases, alternating the enable.
        for (int p = 0; p < 5; p++)
        begin
            write_arp_enable(phase_on[p][0]);
            done_items = 0;
            while (done_items < phase_items[p])
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10:
                        it = good_learn(pick_ip(), random_mac());
                    11, 12, 13, 14:
                        it = mark_item($urandom_range(0, 1) ? CMD_BLOCK : CMD_UNBLOCK, pick_ip());
                    15, 16, 17:
                        it = broken_learn();
                    default:
                        it = noise_item();
                endcase
                send_paced(it);
                done_items++;
                // Let the pipeline run dry once in the middle of the first phase.
                if (p == 0 && done_items == phase_items[p] / 2)
                begin
                    wait_for_results();
                end
            end
            wait_for_results();
        end

        $display("Run covered %0d items and %0d results; table peaked at %0d entries.",
                 sb.items_noted, sb.results_seen, sb.peak_fill);
        $display("Outcome kinds seen (bit per code): %08b", sb.kinds_seen);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("[arp_snooping_device_table] OK");
        end
        else
        begin
            $display("[arp_snooping_device_table] ERROR");
        end
        $finish;
    end

endmodule

FILE: arp_snooping_device_table.f
+incdir+design
design/arpsdt_pkg.sv
design/arpsdt_table.sv
design/arp_snooping_device_table.sv
tb/testbench.sv
